### rtl/rfzp_pkg.sv
// Shared constants, types and codes for the zero-padded row FIR.
package rfzp_pkg;

	// Parameter defaults
	localparam int MAX_TAPS_DEF    = 8;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths
	localparam int COEF_BITS     = 16;
	localparam int COEF_FRAC     = 14;
	localparam int NUM_COEFS     = 8;
	localparam int COEF_IDX_BITS = 3;
	localparam int TAP_BITS      = 4;
	localparam int REG_BITS      = 64;
	localparam int CFG_IDX_BITS  = 2;
	localparam int OUT_BITS      = 16;
	localparam int OUT_MAX       = 2 ** (OUT_BITS - 1) - 1;
	localparam int MAX_RESULTS   = 5;

	// Register reset values
	localparam logic [TAP_BITS-1:0] TAP_COUNT_RST  = TAP_BITS'(1);
	localparam logic [REG_BITS-1:0] COEFS_LOW_RST  = REG_BITS'(16384);
	localparam logic [REG_BITS-1:0] COEFS_HIGH_RST = '0;

	// Register map
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TAP_COUNT  = 2'd0,
		REG_COEFS_LOW  = 2'd1,
		REG_COEFS_HIGH = 2'd2
	} cfg_reg_t;

	// All eight Q2.14 coefficients, tap 0 in the low word
	typedef logic [NUM_COEFS-1:0][COEF_BITS-1:0] coef_vec_t;

	// Control that travels with one result through the datapath
	typedef struct packed {
		logic valid;
		logic row_last;
		logic run_last;
		logic clear;
	} job_flags_t;

	// One output beat
	typedef struct packed {
		logic [OUT_BITS-1:0] filtered;
		logic                row_last;
		logic                run_last;
	} out_beat_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_BURST
	} seq_state_t;

endpackage

### rtl/rfzp_seq.sv
// Result sequencer: pending count, input handshake and per-result issue.
module rfzp_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          row_end,
	input  logic [rfzp_pkg::TAP_BITS-1:0] t,
	input  logic                          room,
	output logic                          in_stall,
	output logic                          accept,
	output logic                          issue,
	output logic [rfzp_pkg::TAP_BITS-1:0] d_s1,
	output rfzp_pkg::job_flags_t          flags_s1
);
	import rfzp_pkg::*;

	seq_state_t          state_q, state_d;
	logic [TAP_BITS-1:0] pend_q, pend_d;
	logic [TAP_BITS-1:0] cur_p_q, cur_p_d;
	logic [TAP_BITS-1:0] rem_q, rem_d;
	logic                last_q, last_d;

	logic [TAP_BITS-1:0] half, lookahead, limit, p_acc, excess, n_res;
	logic [TAP_BITS-1:0] job_p;
	logic                over, job_fin, job_last;

	// Window geometry and number of results the incoming beat releases
	always_comb begin
		half      = t >> 1;
		lookahead = t - TAP_BITS'(1) - half;
		limit     = row_end ? '0 : lookahead;
		p_acc     = pend_q + TAP_BITS'(1);
		over      = p_acc > limit;
		excess    = p_acc - limit;
		n_res     = (excess > TAP_BITS'(MAX_RESULTS)) ? TAP_BITS'(MAX_RESULTS) : excess;
	end

	// Next state and issue
	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		cur_p_d  = cur_p_q;
		rem_d    = rem_q;
		last_d   = last_q;
		issue    = 1'b0;
		accept   = 1'b0;
		in_stall = 1'b1;
		job_p    = p_acc;
		job_fin  = 1'b0;
		job_last = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				in_stall = !room;
				accept   = in_valid && room;
				if (accept) begin
					if (over) begin
						issue    = 1'b1;
						job_p    = p_acc;
						job_fin  = (n_res == TAP_BITS'(1));
						job_last = row_end;
						pend_d   = row_end ? '0 : p_acc - n_res;
						if (!job_fin) begin
							state_d = SEQ_BURST;
							cur_p_d = p_acc - TAP_BITS'(1);
							rem_d   = n_res - TAP_BITS'(1);
							last_d  = row_end;
						end
					end else begin
						pend_d = row_end ? '0 : p_acc;
					end
				end
			end
			SEQ_BURST: begin
				if (room) begin
					issue    = 1'b1;
					job_p    = cur_p_q;
					job_fin  = (rem_q == TAP_BITS'(1));
					job_last = last_q;
					cur_p_d  = cur_p_q - TAP_BITS'(1);
					rem_d    = rem_q - TAP_BITS'(1);
					if (job_fin) begin
						state_d = SEQ_IDLE;
					end
				end
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pend_q  <= '0;
			cur_p_q <= '0;
			rem_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			cur_p_q <= cur_p_d;
			rem_q   <= rem_d;
			last_q  <= last_d;
		end
	end

	// Issue stage: tap offset and flags for the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
		end else begin
			flags_s1.valid    <= issue;
			flags_s1.run_last <= issue && job_fin;
			flags_s1.row_last <= issue && job_fin && job_last;
			flags_s1.clear    <= issue && job_fin && job_last;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			d_s1 <= job_p - TAP_BITS'(1) + half;
		end
	end

	// A burst always has a result left to issue
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_BURST |-> rem_q != '0)
		else $error("burst with no result left");

	// The row flush closes the run it belongs to
	assert property (@(posedge clk) disable iff (!arst_n)
		flags_s1.clear |-> flags_s1.valid && flags_s1.run_last && flags_s1.row_last)
		else $error("window clear on a result that does not end the row");

	// Row end leaves nothing pending
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_end |=> pend_q == '0)
		else $error("pending count not cleared at row end");

endmodule

### rtl/rfzp_cell.sv
// One tap cell: a window sample, its coefficient pick and a registered product.
module rfzp_cell #(
	parameter int INDEX       = 0,
	parameter int SAMPLE_BITS = rfzp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          shift,
	input  logic                                          clear,
	input  logic signed [SAMPLE_BITS-1:0]                 prev,
	input  logic [rfzp_pkg::TAP_BITS-1:0]                 d,
	input  logic [rfzp_pkg::TAP_BITS-1:0]                 t,
	input  rfzp_pkg::coef_vec_t                           coefs,
	output logic signed [SAMPLE_BITS-1:0]                 win,
	output logic signed [SAMPLE_BITS+rfzp_pkg::COEF_BITS-1:0] prod_s2
);
	import rfzp_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam logic [TAP_BITS:0] IDX = (TAP_BITS + 1)'(INDEX);

	logic signed [SAMPLE_BITS-1:0] win_q;
	logic [TAP_BITS:0]             dx, jx;
	logic signed [COEF_BITS-1:0]   coef_sel;

	// Tap that meets this sample for the current result, zero when outside the kernel
	always_comb begin
		dx       = {1'b0, d};
		jx       = dx - IDX;
		coef_sel = '0;
		if (dx >= IDX && jx < {1'b0, t} && jx < (TAP_BITS + 1)'(NUM_COEFS)) begin
			coef_sel = coefs[jx[COEF_IDX_BITS-1:0]];
		end
	end

	// Window sample: shifts on each input beat, cleared after a row flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= (clear && INDEX != 0) ? '0 : prev;
		end else if (clear) begin
			win_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(win_q * coef_sel);
	end

	assign win = win_q;

endmodule

### rtl/rfzp_tree.sv
// Registered adder tree over the cell products, flag delay line and output saturation.
module rfzp_tree #(
	parameter int MAX_TAPS = rfzp_pkg::MAX_TAPS_DEF,
	parameter int PROD_W   = rfzp_pkg::SAMPLE_BITS_DEF + rfzp_pkg::COEF_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [MAX_TAPS-1:0][PROD_W-1:0]  prods,
	input  rfzp_pkg::job_flags_t             flags_s1,
	output logic                             push,
	output rfzp_pkg::out_beat_t              beat
);
	import rfzp_pkg::*;

	localparam int LEVELS = $clog2(MAX_TAPS);
	localparam int NP     = 1 << LEVELS;
	localparam int ACC_W  = PROD_W + LEVELS;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-OUT_MAX - 1);

	logic signed [ACC_W-1:0] leaf  [NP];
	logic signed [ACC_W-1:0] sum_q [NP];
	logic signed [ACC_W-1:0] root, shifted;
	job_flags_t              flg_q [LEVELS+1];

	// Leaves, padded with zero up to a power of two
	for (genvar k = 0; k < NP; k++) begin : g_leaf
		if (k < MAX_TAPS) begin : g_used
			assign leaf[k] = ACC_W'($signed(prods[k]));
		end else begin : g_pad
			assign leaf[k] = '0;
		end
	end

	// Heap-ordered nodes, one register per level
	for (genvar k = 0; k < NP - 1; k++) begin : g_node
		if (2 * k + 1 >= NP - 1) begin : g_bottom
			always_ff @(posedge clk) begin
				sum_q[k] <= leaf[2*k+1-(NP-1)] + leaf[2*k+2-(NP-1)];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				sum_q[k] <= sum_q[2*k+1] + sum_q[2*k+2];
			end
		end
	end

	if (LEVELS == 0) begin : g_root_leaf
		assign root = leaf[0];
	end else begin : g_root_node
		assign root = sum_q[0];
	end

	// Flags follow the product stage and each tree level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LEVELS; i++) begin
				flg_q[i] <= '0;
			end
		end else begin
			flg_q[0] <= flags_s1;
			for (int i = 1; i <= LEVELS; i++) begin
				flg_q[i] <= flg_q[i-1];
			end
		end
	end

	// Drop the fraction (floor) and clamp to the output range
	always_comb begin
		shifted = root >>> COEF_FRAC;
		if (shifted > SAT_HI) begin
			beat.filtered = OUT_BITS'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			beat.filtered = OUT_BITS'(SAT_LO);
		end else begin
			beat.filtered = shifted[OUT_BITS-1:0];
		end
		beat.row_last = flg_q[LEVELS].row_last;
		beat.run_last = flg_q[LEVELS].run_last;
	end

	assign push = flg_q[LEVELS].valid;

endmodule

### rtl/rfzp_ofifo.sv
// Output queue with issue credits so results never back up into the tree.
module rfzp_ofifo #(
	parameter int DEPTH = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                issue,
	output logic                room,
	input  logic                push,
	input  rfzp_pkg::out_beat_t push_beat,
	output logic                out_valid,
	input  logic                out_stall,
	output rfzp_pkg::out_beat_t out_beat
);
	import rfzp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	out_beat_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q, cred_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign out_beat  = mem_q[rd_ptr_q];
	assign room      = cred_q < CNT_W'(DEPTH);

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	// Pointers, fill level and credits (results issued but not yet taken)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			cred_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
			cred_q  <= cred_q + CNT_W'(issue) - CNT_W'(pop);
		end
	end

	// Every queued beat was issued against a credit
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cred_q)
		else $error("queue holds more beats than credits issued");

	// Credits bound the queue, so a push never meets a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < CNT_W'(DEPTH))
		else $error("push into a full output queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> cred_q <= CNT_W'(DEPTH))
		else $error("credit count beyond queue depth");

endmodule

### rtl/row_fir_zero_padded.sv
// Top level: zero-padded row FIR as a chain of tap cells feeding a registered adder tree.
// A result passes the issue register, the product register, each tree level and the output queue before out_valid.
// Throughput: one item per cycle while each item frees one result and the output queue has room; an item
// that frees n results holds the input until all n have issued, as the cells form one product per result.
// The output queue holds clog2(MAX_TAPS) + 4 beats, so input keeps flowing while a result waits.
// Reset (arst_n): window, counters and queue cleared; tap_count 1, coefs_low 16384, coefs_high 0.
module row_fir_zero_padded #(
	parameter int MAX_TAPS    = rfzp_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = rfzp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rfzp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [rfzp_pkg::REG_BITS-1:0]          cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [SAMPLE_BITS-1:0]          sample,
	input  logic                                   row_end,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rfzp_pkg::OUT_BITS-1:0]   filtered,
	output logic                                   row_last,
	output logic                                   run_last
);
	import rfzp_pkg::*;

	localparam int LEVELS     = $clog2(MAX_TAPS);
	localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
	localparam int FIFO_DEPTH = LEVELS + 4;
	localparam int T_CAP      = (MAX_TAPS < 15) ? MAX_TAPS : 15;

	logic [TAP_BITS-1:0] tap_count_q;
	logic [REG_BITS-1:0] coefs_low_q, coefs_high_q;
	logic [TAP_BITS-1:0] t_eff;
	coef_vec_t           coefs;

	logic                accept, issue, room, push;
	logic [TAP_BITS-1:0] d_s1;
	job_flags_t          flags_s1;
	out_beat_t           push_beat, out_beat;

	logic signed [SAMPLE_BITS-1:0]   win   [MAX_TAPS];
	logic [MAX_TAPS-1:0][PROD_W-1:0] prods;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= TAP_COUNT_RST;
			coefs_low_q  <= COEFS_LOW_RST;
			coefs_high_q <= COEFS_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TAP_COUNT:  tap_count_q  <= cfg_data[TAP_BITS-1:0];
				REG_COEFS_LOW:  coefs_low_q  <= cfg_data;
				REG_COEFS_HIGH: coefs_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Taps in use, clamped to one..min(MAX_TAPS, 15)
	always_comb begin
		if (tap_count_q == '0) begin
			t_eff = TAP_BITS'(1);
		end else if (tap_count_q > TAP_BITS'(T_CAP)) begin
			t_eff = TAP_BITS'(T_CAP);
		end else begin
			t_eff = tap_count_q;
		end
	end

	assign coefs = {coefs_high_q, coefs_low_q};

	// Sequencer
	rfzp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.row_end  (row_end),
		.t        (t_eff),
		.room     (room),
		.in_stall (in_stall),
		.accept   (accept),
		.issue    (issue),
		.d_s1     (d_s1),
		.flags_s1 (flags_s1)
	);

	// Chain of tap cells, newest sample in cell zero
	for (genvar a = 0; a < MAX_TAPS; a++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] prev;
		logic signed [PROD_W-1:0]      prod;

		if (a == 0) begin : g_head
			assign prev = sample;
		end else begin : g_link
			assign prev = win[a-1];
		end

		rfzp_cell #(
			.INDEX       (a),
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (accept),
			.clear   (flags_s1.clear),
			.prev    (prev),
			.d       (d_s1),
			.t       (t_eff),
			.coefs   (coefs),
			.win     (win[a]),
			.prod_s2 (prod)
		);

		assign prods[a] = prod;
	end

	// Sum and saturate
	rfzp_tree #(
		.MAX_TAPS (MAX_TAPS),
		.PROD_W   (PROD_W)
	) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.prods    (prods),
		.flags_s1 (flags_s1),
		.push     (push),
		.beat     (push_beat)
	);

	// Output queue
	rfzp_ofifo #(
		.DEPTH (FIFO_DEPTH)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.room      (room),
		.push      (push),
		.push_beat (push_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	assign filtered = out_beat.filtered;
	assign row_last = out_beat.row_last;
	assign run_last = out_beat.run_last;

endmodule
